### sv/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Shared constants and controller/datapath interface types for the
// shortest-remaining-time scheduler.
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int MAX_TASKS = 16;
    localparam int TIME_BITS = 16;
    localparam int ID_W      = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = 5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic tick_start;
        logic scan_step;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_end;
    } t_status;

endpackage

### sv/srt_ctrl.sv
// ----------------------------------------------------------------------------
// srt_ctrl
// Sequencer: accepts requests, steps the table scan one entry per cycle
// and closes each tick with an update and report step in the finish state.
// ----------------------------------------------------------------------------
module srt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            i_operation,
    input  srt_pkg::t_status i_status,
    output srt_pkg::t_cmd   o_cmd,
    output logic            busy
);
    import srt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_operation == OP_TICK) begin
                        o_cmd.tick_start = 1'b1;
                        n_state          = S_SCAN;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (i_status.scan_end) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

### sv/srt_datapath.sv
// ----------------------------------------------------------------------------
// srt_datapath
// Task tables, time counter, sequential minimum search and result register.
// ----------------------------------------------------------------------------
module srt_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srt_pkg::t_cmd                 i_cmd,
    output srt_pkg::t_status              o_status,
    input  logic                          i_cfg_valid,
    input  logic [srt_pkg::CNT_W-1:0]     i_cfg_task_count,
    input  logic [srt_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [srt_pkg::ID_W-1:0]      i_task_id,
    input  logic [srt_pkg::TIME_BITS-1:0] i_arrival_time,
    input  logic [srt_pkg::TIME_BITS-1:0] i_burst_length,
    output logic                          o_result_valid,
    output logic                          o_ran_task,
    output logic [srt_pkg::ID_W-1:0]      o_running_id,
    output logic [srt_pkg::TIME_BITS-1:0] o_tick_time,
    output logic                          o_task_finished,
    output logic                          o_all_done
);
    import srt_pkg::*;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // Task tables; entries are undefined until loaded.
    logic [ID_W-1:0]      r_id_tab   [MAX_TASKS];
    logic [TIME_BITS-1:0] r_arr_tab  [MAX_TASKS];
    logic [TIME_BITS-1:0] r_rem_tab  [MAX_TASKS];

    logic [CNT_W-1:0]     r_task_count;
    logic [TIME_BITS-1:0] r_time;

    // Scan state.
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best_idx;
    logic [TIME_BITS-1:0] r_best_rem;
    logic [ID_W-1:0]      r_best_id;
    logic [CNT_W-1:0]     r_unfin;

    logic [CNT_W-1:0]     n_in_use;
    logic [IDX_W-1:0]     scan_idx;
    logic [TIME_BITS-1:0] scan_rem;
    logic                 scan_live;
    logic                 scan_better;
    logic                 any_unfin;
    logic                 ran;
    logic                 fin;

    // Entries in use, limited to the table depth.
    assign n_in_use = (r_task_count > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS)
                                                         : r_task_count;

    assign o_status.scan_end = (r_cnt == n_in_use);

    // Candidate test for the entry under the scan pointer.
    assign scan_idx    = r_cnt[IDX_W-1:0];
    assign scan_rem    = r_rem_tab[scan_idx];
    assign scan_live   = (scan_rem != '0);
    assign scan_better = scan_live && (r_arr_tab[scan_idx] <= r_time)
                         && (!r_found || (scan_rem < r_best_rem));

    // Tick outcome from the finished scan.
    assign any_unfin = (r_unfin != '0);
    assign ran       = any_unfin && r_found;
    assign fin       = ran && (r_best_rem == TIME_BITS'(1));

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= '0;
        end else if (i_cfg_valid) begin
            r_task_count <= i_cfg_task_count;
        end
    end

    // Table writes: loads fill an entry, the closing tick cycle decrements.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && ({1'b0, i_entry_index} < (IDX_W+1)'(MAX_TASKS))) begin
            r_id_tab[i_entry_index]  <= i_task_id;
            r_arr_tab[i_entry_index] <= i_arrival_time;
            r_rem_tab[i_entry_index] <= i_burst_length;
        end else if (i_cmd.finish && ran) begin
            r_rem_tab[r_best_idx] <= r_best_rem - TIME_BITS'(1);
        end
    end

    // Scan pointer, running minimum and count of unfinished entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_found <= 1'b0;
            r_unfin <= '0;
        end else if (i_cmd.tick_start) begin
            r_cnt   <= '0;
            r_found <= 1'b0;
            r_unfin <= '0;
        end else if (i_cmd.scan_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (scan_live) begin
                r_unfin <= r_unfin + CNT_W'(1);
            end
            if (scan_better) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && scan_better) begin
            r_best_idx <= scan_idx;
            r_best_rem <= scan_rem;
            r_best_id  <= r_id_tab[scan_idx];
        end
    end

    // Time counter advances, saturating, unless the schedule has completed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else if (i_cmd.finish && any_unfin && (r_time != TIME_MAX)) begin
            r_time <= r_time + TIME_BITS'(1);
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.finish;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_ran_task      <= ran;
            o_running_id    <= ran ? r_best_id : '0;
            o_tick_time     <= r_time;
            o_task_finished <= fin;
            o_all_done      <= !any_unfin || (fin && (r_unfin == CNT_W'(1)));
        end
    end

endmodule

### sv/shortest_remaining_time_scheduler.sv
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler
// Preemptive shortest-remaining-time-first scheduler over a task table.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start/busy; a request is taken at a clock edge with
//   start high and busy low. i_operation selects a load (writes one table
//   entry: id, arrival time, burst length) or a tick.
//   A load produces no result and never raises busy.
//   A tick scans the N entries in use, one entry per cycle, then sees the
//   end of the scan, then in the finish state updates the chosen entry and
//   the time counter. The result is on the o_ ports for one cycle, marked by
//   o_result_valid, registered from the finish state; busy is low again
//   in that cycle, so the next request is taken at the edge that ends it.
//   The receiver cannot hold results off; each result is shown once.
//   The task count register is written over i_cfg_valid/o_cfg_ready, which
//   is always ready; write it only while the block is idle.
//   Reset clears the time counter, the task count and the control state;
//   table entries are undefined until loaded.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_operation,
    input  logic [srt_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [srt_pkg::ID_W-1:0]      i_task_id,
    input  logic [srt_pkg::TIME_BITS-1:0] i_arrival_time,
    input  logic [srt_pkg::TIME_BITS-1:0] i_burst_length,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [srt_pkg::CNT_W-1:0]     i_cfg_task_count,
    output logic                          o_result_valid,
    output logic                          o_ran_task,
    output logic [srt_pkg::ID_W-1:0]      o_running_id,
    output logic [srt_pkg::TIME_BITS-1:0] o_tick_time,
    output logic                          o_task_finished,
    output logic                          o_all_done
);
    import srt_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    // Sequencer.
    srt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_status    (status),
        .o_cmd       (cmd),
        .busy        (busy)
    );

    // Tables, scan and result register.
    srt_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_task_count (i_cfg_task_count),
        .i_entry_index    (i_entry_index),
        .i_task_id        (i_task_id),
        .i_arrival_time   (i_arrival_time),
        .i_burst_length   (i_burst_length),
        .o_result_valid   (o_result_valid),
        .o_ran_task       (o_ran_task),
        .o_running_id     (o_running_id),
        .o_tick_time      (o_tick_time),
        .o_task_finished  (o_task_finished),
        .o_all_done       (o_all_done)
    );

endmodule
